// ===== rtl/lcdfmt_pkg.sv =====
// lcdfmt_pkg: shared types and constants for the character lcd command formatter
// used by lcdfmt_ctrl, lcdfmt_dp and the top level; depends on nothing
`timescale 1ns / 1ps
`default_nettype none

package lcdfmt_pkg;

    localparam int MAX_DIGITS = 8;
    localparam int CNT_W      = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

    // request codes
    localparam logic [2:0] REQ_INIT   = 3'd0;
    localparam logic [2:0] REQ_MODE   = 3'd1;
    localparam logic [2:0] REQ_CLEAR  = 3'd2;
    localparam logic [2:0] REQ_HOME   = 3'd3;
    localparam logic [2:0] REQ_CHAR   = 3'd4;
    localparam logic [2:0] REQ_NUMBER = 3'd5;

    // lcd command bytes
    localparam logic [7:0] CMD_FUNC_SET   = 8'h38;
    localparam logic [7:0] CMD_ENTRY_MODE = 8'h06;
    localparam logic [7:0] CMD_DISP_CTRL  = 8'h08;
    localparam logic [7:0] CMD_CLEAR      = 8'h01;
    localparam logic [7:0] CMD_HOME       = 8'h02;

    localparam logic [7:0] CHR_SPACE = 8'h20;
    localparam logic [7:0] CHR_ZERO  = 8'h30;
    localparam logic [7:0] CHR_NINE  = 8'h39;

    // reciprocal of ten, exact for 16-bit operands after a 19-bit shift
    localparam logic [16:0] RECIP_10 = 17'd52429;
    localparam int          RECIP_SH = 19;

    localparam logic RS_CMD  = 1'b0;
    localparam logic RS_DATA = 1'b1;

    typedef enum logic [2:0] {
        SEL_INIT0,
        SEL_INIT1,
        SEL_SINGLE,
        SEL_ADDR,
        SEL_DATA
    } emit_sel_t;

    typedef struct packed {
        logic      load;       // capture a new request
        logic      conv_step;  // one decimal digit
        logic      cnt_clear;  // reset place counter
        logic      emit;       // write one beat into the output register
        emit_sel_t sel;        // which byte to emit
        logic      place_adv;  // move to next place after a data write
    } dp_cmd_t;

    typedef struct packed {
        logic       cnt_last;  // place counter at last place
        logic       slot_free; // output register can take a beat
    } dp_status_t;

endpackage

`default_nettype wire

// ===== rtl/char_lcd_command_formatter_unit.sv =====
// char_lcd_command_formatter_unit: top level joining sequencer and datapath
// depends on lcdfmt_pkg, lcdfmt_ctrl, lcdfmt_dp
`timescale 1ns / 1ps
`default_nettype none

// Turns one request into the byte writes for a 16x2 character lcd. Each
// output beat carries reg_select (0 command, 1 data), bus_byte and last,
// which marks the final write of the request. init gives 0x38 then 0x06;
// mode gives 0x08 with display, cursor and blink bits; clear gives 0x01 and
// home 0x02; char gives an address command then the character. number shows
// value right-justified in decimal over field_width places (clamped to 1..8),
// spaces in front, low digits kept on overflow, a lone '0' for zero, each
// place as an address/data pair with the column wrapping on the same row.
// Request codes 6 and 7 produce no writes. One request is in work at a time:
// a number first passes place by place through the divide-by-ten digit unit,
// then the writes go out through the output register, each one waiting while
// the register holds a beat not yet taken. The next request is taken as soon
// as the last write sits in the output register.

module char_lcd_command_formatter_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [2:0]  req_type,
    input  wire logic [3:0]  col,
    input  wire logic        row,
    input  wire logic [7:0]  char_code,
    input  wire logic [15:0] value,
    input  wire logic [3:0]  field_width,
    input  wire logic        display_enable,
    input  wire logic        cursor_enable,
    input  wire logic        blink_enable,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             reg_select,
    output logic [7:0]       bus_byte,
    output logic             last
);

    // command and status between sequencer and datapath
    lcdfmt_pkg::dp_cmd_t    cmd;
    lcdfmt_pkg::dp_status_t status;

    lcdfmt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .req_type (req_type),
        .status   (status),
        .cmd      (cmd)
    );

    lcdfmt_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .req_type       (req_type),
        .col            (col),
        .row            (row),
        .char_code      (char_code),
        .value          (value),
        .field_width    (field_width),
        .display_enable (display_enable),
        .cursor_enable  (cursor_enable),
        .blink_enable   (blink_enable),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .reg_select     (reg_select),
        .bus_byte       (bus_byte),
        .last           (last)
    );

    // a known request keeps the block busy in the next cycle
    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (req_type <= lcdfmt_pkg::REQ_NUMBER) |=> !in_ready)
        else $error("formatter took a request while busy");

    // an address command is always followed by its data beat
    a_addr_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (reg_select == lcdfmt_pkg::RS_CMD) && bus_byte[7] |-> !last)
        else $error("address command marked last");

    // data beats before the last one are number places: digit or space
    a_place_chr: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (reg_select == lcdfmt_pkg::RS_DATA) && !last |->
        (bus_byte == lcdfmt_pkg::CHR_SPACE) ||
        ((bus_byte >= lcdfmt_pkg::CHR_ZERO) && (bus_byte <= lcdfmt_pkg::CHR_NINE)))
        else $error("number place is not a digit or space");

endmodule

`default_nettype wire

// ===== rtl/lcdfmt_dp.sv =====
// lcdfmt_dp: request registers, decimal digit unit, place buffer and output register
// depends on lcdfmt_pkg
`timescale 1ns / 1ps
`default_nettype none

module lcdfmt_dp (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire lcdfmt_pkg::dp_cmd_t  cmd,
    output lcdfmt_pkg::dp_status_t    status,
    input  wire logic [2:0]           req_type,
    input  wire logic [3:0]           col,
    input  wire logic                 row,
    input  wire logic [7:0]           char_code,
    input  wire logic [15:0]          value,
    input  wire logic [3:0]           field_width,
    input  wire logic                 display_enable,
    input  wire logic                 cursor_enable,
    input  wire logic                 blink_enable,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic                      reg_select,
    output logic [7:0]                bus_byte,
    output logic                      last
);

    logic [3:0]                   col_reg, col_next;
    logic                         row_reg;
    logic [7:0]                   single_reg;
    logic [15:0]                  val_reg, val_next;
    logic [lcdfmt_pkg::CNT_W-1:0] wm1_reg, wm1_next;
    logic [lcdfmt_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic [7:0]                   buf_reg  [lcdfmt_pkg::MAX_DIGITS];
    logic [7:0]                   buf_next [lcdfmt_pkg::MAX_DIGITS];
    logic                         out_valid_reg, out_valid_next;
    logic                         rs_reg, rs_next;
    logic [7:0]                   byte_reg, byte_next;
    logic                         last_reg, last_next;
    logic [7:0]                   single_next;

    logic [32:0] prod;
    logic [15:0] quot;
    logic [3:0]  digit;
    logic [7:0]  digit_chr;
    logic        is_last_data;

    // width clamp to 1..MAX_DIGITS, kept as width minus one
    always_comb
    begin
        if (field_width == 4'd0)
            wm1_next = '0;
        else if (field_width > 4'(lcdfmt_pkg::MAX_DIGITS))
            wm1_next = lcdfmt_pkg::CNT_W'(lcdfmt_pkg::MAX_DIGITS - 1);
        else
            wm1_next = lcdfmt_pkg::CNT_W'(field_width - 4'd1);
    end

    always_comb
    begin
        single_next = lcdfmt_pkg::CMD_DISP_CTRL
                    | {5'd0, display_enable, cursor_enable, blink_enable};
        unique case (req_type)
            lcdfmt_pkg::REQ_CLEAR: single_next = lcdfmt_pkg::CMD_CLEAR;
            lcdfmt_pkg::REQ_HOME:  single_next = lcdfmt_pkg::CMD_HOME;
            default: ;
        endcase
    end

    // divide by ten through the reciprocal, remainder by shift and add
    assign prod      = {1'b0, val_reg} * {16'd0, lcdfmt_pkg::RECIP_10};
    assign quot      = prod[lcdfmt_pkg::RECIP_SH +: 16];
    assign digit     = 4'(val_reg - ((quot << 3) + (quot << 1)));
    assign digit_chr = ((cnt_reg == '0) || (val_reg != 16'd0))
                     ? (lcdfmt_pkg::CHR_ZERO | {4'd0, digit}) : lcdfmt_pkg::CHR_SPACE;

    assign is_last_data = (cnt_reg == wm1_reg);

    always_comb
    begin
        col_next = col_reg;
        val_next = val_reg;
        cnt_next = cnt_reg;
        buf_next = buf_reg;
        if (cmd.load) begin
            col_next    = col;
            val_next    = value;
            cnt_next    = '0;
            buf_next[0] = char_code;
        end
        if (cmd.conv_step) begin
            val_next    = quot;
            cnt_next    = cnt_reg + 1'b1;
            buf_next[0] = digit_chr;
            for (int k = 1; k < lcdfmt_pkg::MAX_DIGITS; k++)
                buf_next[k] = buf_reg[k-1];
        end
        if (cmd.place_adv) begin
            col_next = col_reg + 4'd1;
            cnt_next = cnt_reg + 1'b1;
            for (int k = 0; k < lcdfmt_pkg::MAX_DIGITS - 1; k++)
                buf_next[k] = buf_reg[k+1];
            buf_next[lcdfmt_pkg::MAX_DIGITS-1] = lcdfmt_pkg::CHR_SPACE;
        end
        if (cmd.cnt_clear)
            cnt_next = '0;
    end

    // output beat register
    always_comb
    begin
        out_valid_next = out_valid_reg & ~out_ready;
        rs_next        = rs_reg;
        byte_next      = byte_reg;
        last_next      = last_reg;
        if (cmd.emit) begin
            out_valid_next = 1'b1;
            unique case (cmd.sel)
                lcdfmt_pkg::SEL_INIT0:
                begin
                    rs_next   = lcdfmt_pkg::RS_CMD;
                    byte_next = lcdfmt_pkg::CMD_FUNC_SET;
                    last_next = 1'b0;
                end
                lcdfmt_pkg::SEL_INIT1:
                begin
                    rs_next   = lcdfmt_pkg::RS_CMD;
                    byte_next = lcdfmt_pkg::CMD_ENTRY_MODE;
                    last_next = 1'b1;
                end
                lcdfmt_pkg::SEL_SINGLE:
                begin
                    rs_next   = lcdfmt_pkg::RS_CMD;
                    byte_next = single_reg;
                    last_next = 1'b1;
                end
                lcdfmt_pkg::SEL_ADDR:
                begin
                    rs_next   = lcdfmt_pkg::RS_CMD;
                    byte_next = {1'b1, row_reg, 2'b00, col_reg};
                    last_next = 1'b0;
                end
                default:
                begin
                    rs_next   = lcdfmt_pkg::RS_DATA;
                    byte_next = buf_reg[0];
                    last_next = is_last_data;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load) begin
            row_reg    <= row;
            single_reg <= single_next;
            wm1_reg    <= (req_type == lcdfmt_pkg::REQ_NUMBER) ? wm1_next : '0;
        end
        col_reg  <= col_next;
        val_reg  <= val_next;
        cnt_reg  <= cnt_next;
        buf_reg  <= buf_next;
        rs_reg   <= rs_next;
        byte_reg <= byte_next;
        last_reg <= last_next;
    end

    assign status.cnt_last  = is_last_data;
    assign status.slot_free = ~out_valid_reg | out_ready;

    assign out_valid  = out_valid_reg;
    assign reg_select = rs_reg;
    assign bus_byte   = byte_reg;
    assign last       = last_reg;

endmodule

`default_nettype wire

// ===== rtl/lcdfmt_ctrl.sv =====
// lcdfmt_ctrl: sequencer that steps one request through its bus writes
// depends on lcdfmt_pkg
`timescale 1ns / 1ps
`default_nettype none

module lcdfmt_ctrl (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic [2:0]             req_type,
    input  wire lcdfmt_pkg::dp_status_t status,
    output lcdfmt_pkg::dp_cmd_t         cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT0,
        ST_INIT1,
        ST_SINGLE,
        ST_CONV,
        ST_ADDR,
        ST_DATA
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        cmd.sel       = lcdfmt_pkg::SEL_ADDR;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid) begin
                    cmd.load = 1'b1;
                    unique case (req_type)
                        lcdfmt_pkg::REQ_INIT:   state_next = ST_INIT0;
                        lcdfmt_pkg::REQ_MODE,
                        lcdfmt_pkg::REQ_CLEAR,
                        lcdfmt_pkg::REQ_HOME:   state_next = ST_SINGLE;
                        lcdfmt_pkg::REQ_CHAR:   state_next = ST_ADDR;
                        lcdfmt_pkg::REQ_NUMBER: state_next = ST_CONV;
                        default:                state_next = ST_IDLE;
                    endcase
                end
            end
            ST_INIT0:
            begin
                cmd.sel = lcdfmt_pkg::SEL_INIT0;
                if (status.slot_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_INIT1;
                end
            end
            ST_INIT1:
            begin
                cmd.sel = lcdfmt_pkg::SEL_INIT1;
                if (status.slot_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_SINGLE:
            begin
                cmd.sel = lcdfmt_pkg::SEL_SINGLE;
                if (status.slot_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_CONV:
            begin
                cmd.conv_step = 1'b1;
                if (status.cnt_last) begin
                    cmd.cnt_clear = 1'b1;
                    state_next    = ST_ADDR;
                end
            end
            ST_ADDR:
            begin
                cmd.sel = lcdfmt_pkg::SEL_ADDR;
                if (status.slot_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_DATA;
                end
            end
            ST_DATA:
            begin
                cmd.sel = lcdfmt_pkg::SEL_DATA;
                if (status.slot_free) begin
                    cmd.emit      = 1'b1;
                    cmd.place_adv = 1'b1;
                    state_next    = status.cnt_last ? ST_IDLE : ST_ADDR;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    assign in_ready = (state_reg == ST_IDLE);

endmodule

`default_nettype wire
